/* hw/rtl/kron_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kron_pkg;

  // Field widths of the stream payloads
  localparam int A_BITS           = 64;
  localparam int MOD_BITS         = 63;
  localparam int IN_DATA_BITS     = 128;
  localparam int SYM_BITS         = 2;
  localparam int OUT_DATA_BITS    = 8;
  localparam int DEFAULT_WORD_BITS = 64;

  // Symbol encodings, two's complement in SYM_BITS bits
  localparam logic [SYM_BITS-1:0] SYM_ZERO = 2'b00;
  localparam logic [SYM_BITS-1:0] SYM_POS  = 2'b01;
  localparam logic [SYM_BITS-1:0] SYM_NEG  = 2'b11;

  // Residues used by the sign rules
  localparam logic [2:0] RES8_ONE   = 3'd1;
  localparam logic [2:0] RES8_THREE = 3'd3;
  localparam logic [2:0] RES8_FIVE  = 3'd5;
  localparam logic [2:0] RES8_SEVEN = 3'd7;
  localparam logic [1:0] RES4_THREE = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/kronecker_symbol_binary_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Kronecker symbol (a/p) by the binary Jacobi method.
//
// Input stream: one transaction carries a signed numerator a_value and an
// unsigned modulus; the block answers each with exactly one result
// transaction holding the symbol (-1, 0, +1) and a bad_modulus flag.
// The low WORD_BITS bits of a_value and the low WORD_BITS-1 bits of
// modulus are used.
//
// Modulus 2 and bad moduli (zero, or even and not 2) are decided at
// acceptance and written straight into the output register. An odd modulus
// runs the loop, one step per cycle on a single shared subtractor (strip
// a two, swap, or subtract and halve), until the value reaches zero; the
// result then goes into the output register once that register is free.
// One item is in work at a time; in_tready is high only in idle while the
// output register is free or being drained.
// Reset (rst_n low, synchronous) drops any item in work and any pending
// result. When the receiver stalls, the result holds in the output
// register and no new item is accepted until it is taken.
module kronecker_symbol_binary_core #(
  parameter int WORD_BITS = kron_pkg::DEFAULT_WORD_BITS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [63:0] a_value, [126:64] modulus, [127] zero
  input  wire  [kron_pkg::IN_DATA_BITS-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [1:0] symbol, [7:2] zero
  output logic [kron_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // [0] bad_modulus
  output logic                               out_tuser
);
  import kron_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] x_r, x_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_BITS-1:0]  out_sym_r, out_sym_nxt;
  logic                 out_bad_r, out_bad_nxt;

  logic [A_BITS-1:0]    in_a;
  logic [MOD_BITS-1:0]  in_mod;
  logic [WORD_BITS-1:0] op_a;
  logic [WORD_BITS-1:0] op_m;
  logic [WORD_BITS-1:0] op_mag;
  logic                 op_neg;
  logic                 in_fire;
  logic                 slot_free;
  logic [WORD_BITS:0]   diff;
  logic                 borrow;
  logic                 m_flip2;

  assign in_a   = in_tdata[A_BITS-1:0];
  assign in_mod = in_tdata[A_BITS+MOD_BITS-1:A_BITS];

  // Take operands at the configured width
  assign op_a   = in_a[WORD_BITS-1:0];
  assign op_m   = {1'b0, in_mod[WORD_BITS-2:0]};
  assign op_neg = op_a[WORD_BITS-1];
  assign op_mag = op_neg ? (~op_a + {{(WORD_BITS-1){1'b0}}, 1'b1}) : op_a;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  // Shared subtractor: compare and difference in one
  assign diff   = {1'b0, x_r} - {1'b0, m_r};
  assign borrow = diff[WORD_BITS];

  // Sign flip for a factor of two: modulus 3 or 5 mod 8
  assign m_flip2 = (m_r[2:0] == RES8_THREE) || (m_r[2:0] == RES8_FIVE);

  // Sequencer and output register next state
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_m == {{(WORD_BITS-2){1'b0}}, 2'b10}) begin
            // Decide modulus 2 from a mod 8
            out_valid_nxt = 1'b1;
            out_bad_nxt   = 1'b0;
            if (!op_a[0]) begin
              out_sym_nxt = SYM_ZERO;
            end else if ((op_a[2:0] == RES8_ONE) || (op_a[2:0] == RES8_SEVEN)) begin
              out_sym_nxt = SYM_POS;
            end else begin
              out_sym_nxt = SYM_NEG;
            end
          end else if (!op_m[0]) begin
            // Zero or even modulus other than 2
            out_valid_nxt = 1'b1;
            out_bad_nxt   = 1'b1;
            out_sym_nxt   = SYM_ZERO;
          end else begin
            x_nxt     = op_mag;
            m_nxt     = op_m;
            neg_nxt   = op_neg && (op_m[1:0] == RES4_THREE);
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (x_r == '0) begin
          // Finish once the output register can take the result
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_bad_nxt   = 1'b0;
            if (m_r == {{(WORD_BITS-1){1'b0}}, 1'b1}) begin
              out_sym_nxt = neg_r ? SYM_NEG : SYM_POS;
            end else begin
              out_sym_nxt = SYM_ZERO;
            end
            state_nxt = ST_IDLE;
          end
        end else if (!x_r[0]) begin
          // Strip a factor of two
          x_nxt   = x_r >> 1;
          neg_nxt = neg_r ^ m_flip2;
        end else if (borrow) begin
          // Swap with the reciprocity flip
          x_nxt   = m_r;
          m_nxt   = x_r;
          neg_nxt = neg_r ^ ((x_r[1:0] == RES4_THREE) && (m_r[1:0] == RES4_THREE));
        end else begin
          // Subtract and halve
          x_nxt   = diff[WORD_BITS-1:0] >> 1;
          neg_nxt = neg_r ^ m_flip2;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r       <= x_nxt;
    m_r       <= m_nxt;
    neg_r     <= neg_nxt;
    out_sym_r <= out_sym_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-SYM_BITS){1'b0}}, out_sym_r};
  assign out_tuser  = out_bad_r;

  // A flagged modulus always reports a zero symbol
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_sym_r == SYM_ZERO)
    else $error("bad modulus with nonzero symbol");

  // The loop keeps an odd modulus
  a_mod_odd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> m_r[0])
    else $error("even modulus inside the loop");

  // A running item finishes only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && state_nxt == ST_IDLE |-> slot_free)
    else $error("result written over a pending one");

  // Never accept while an item is in the loop
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !in_tready)
    else $error("input accepted while busy");

endmodule

`default_nettype wire
